/* sv/dalt_pkg.sv */
package dalt_pkg;

  localparam int LightW = 10;
  localparam int DriveW = 16;
  localparam int BiasW  = 10;
  localparam int TickW  = 4;
  localparam int LedW   = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [DriveW-1:0] CwDriveReset   = 16'd3500;
  localparam logic [DriveW-1:0] PanCcwReset    = 16'd3890;
  localparam logic [DriveW-1:0] TiltCcwReset   = 16'd4000;
  localparam logic [BiasW-1:0]  LeftBiasReset  = 10'd100;
  localparam logic [BiasW-1:0]  TopBiasReset   = 10'd160;
  localparam logic [BiasW-1:0]  DeadBandReset  = 10'd20;
  localparam logic [TickW-1:0]  StopTickReset  = 4'd3;
  localparam logic [TickW-1:0]  SampleTickReset = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CW_DRIVE    = 3'd0,
    REG_PAN_CCW     = 3'd1,
    REG_TILT_CCW    = 3'd2,
    REG_LEFT_BIAS   = 3'd3,
    REG_TOP_BIAS    = 3'd4,
    REG_DEAD_BAND   = 3'd5,
    REG_STOP_TICK   = 3'd6,
    REG_SAMPLE_TICK = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [DriveW-1:0] clockwise_drive;
    logic [DriveW-1:0] pan_ccw_drive;
    logic [DriveW-1:0] tilt_ccw_drive;
    logic [BiasW-1:0]  left_bias;
    logic [BiasW-1:0]  top_bias;
    logic [BiasW-1:0]  dead_band;
    logic [TickW-1:0]  stop_tick;
    logic [TickW-1:0]  sample_tick;
  } cfg_t;

  typedef struct packed {
    logic [LightW-1:0] top_left_light;
    logic [LightW-1:0] top_right_light;
    logic [LightW-1:0] bottom_left_light;
    logic [LightW-1:0] bottom_right_light;
  } sample_word_t;

  typedef struct packed {
    logic [DriveW-1:0] tilt_drive;
    logic [DriveW-1:0] pan_drive;
    logic [LedW-1:0]   led_pattern;
    logic              evaluated;
  } result_word_t;

  typedef struct packed {
    logic [TickW-1:0]  tick_count;
    logic [DriveW-1:0] tilt_level;
    logic [DriveW-1:0] pan_level;
    logic [LedW-1:0]   led_level;
  } track_state_t;

endpackage

/* sv/dalt_sample_if.sv */
interface dalt_sample_if;
  import dalt_pkg::*;

  logic         valid;
  logic         ready;
  sample_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/dalt_result_if.sv */
interface dalt_result_if;
  import dalt_pkg::*;

  logic         valid;
  logic         ready;
  result_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/dual_axis_light_tracker.sv */
// Dual-axis light tracker.
// samples: one word per PWM period tick, four 10-bit light readings.
// result:  one word per tick: held tilt and pan compare values, LED byte of
//          the bottom pair average, and a flag set on evaluating ticks.
// cfg_we/cfg_index/cfg_data: register writes, taken on any edge with cfg_we
//          high; write only while no word is in flight.
// An accepted sample word is held in the input register; the tick/average/
// dead-band logic then feeds the state and result registers, which present
// its result word. One word per cycle is sustained while the receiver is
// ready; input and result registers form a two-deep pipe, so a stalled
// receiver holds the result word steady while one further sample word is
// taken, after which samples.ready drops until the result moves.
// Reset clears the tick count and drive levels, empties the pipe and loads
// the default register values; samples.ready is low during reset.
module dual_axis_light_tracker (
  input  logic                           clk,
  input  logic                           rst,
  dalt_sample_if.sink                    samples,
  dalt_result_if.source                  result,
  input  logic                           cfg_we,
  input  logic [dalt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dalt_pkg::CfgDataW-1:0]  cfg_data
);
  import dalt_pkg::*;

  cfg_t         cfg;
  sample_word_t in_word;
  logic         in_valid;
  track_state_t state;
  track_state_t state_next;
  logic         evaluated_next;
  logic         evaluated;
  logic         out_valid;
  logic         advance;
  cfg_index_t   cfg_sel;

  assign cfg_sel = cfg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clockwise_drive <= CwDriveReset;
      cfg.pan_ccw_drive   <= PanCcwReset;
      cfg.tilt_ccw_drive  <= TiltCcwReset;
      cfg.left_bias       <= LeftBiasReset;
      cfg.top_bias        <= TopBiasReset;
      cfg.dead_band       <= DeadBandReset;
      cfg.stop_tick       <= StopTickReset;
      cfg.sample_tick     <= SampleTickReset;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_CW_DRIVE:    cfg.clockwise_drive <= cfg_data;
        REG_PAN_CCW:     cfg.pan_ccw_drive   <= cfg_data;
        REG_TILT_CCW:    cfg.tilt_ccw_drive  <= cfg_data;
        REG_LEFT_BIAS:   cfg.left_bias       <= cfg_data[BiasW-1:0];
        REG_TOP_BIAS:    cfg.top_bias        <= cfg_data[BiasW-1:0];
        REG_DEAD_BAND:   cfg.dead_band       <= cfg_data[BiasW-1:0];
        REG_STOP_TICK:   cfg.stop_tick       <= cfg_data[TickW-1:0];
        REG_SAMPLE_TICK: cfg.sample_tick     <= cfg_data[TickW-1:0];
      endcase
    end
  end

  // result register free, or emptying this cycle
  assign advance       = !out_valid || result.ready;
  assign samples.ready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (samples.valid && samples.ready) begin
      in_word <= samples.data;
    end
  end

  dalt_eval u_eval (
    .word       (in_word),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .evaluated  (evaluated_next)
  );

  // state doubles as the result payload: it only moves when a word enters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      evaluated <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state     <= state_next;
        evaluated <= evaluated_next;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.data.tilt_drive  = state.tilt_level;
  assign result.data.pan_drive   = state.pan_level;
  assign result.data.led_pattern = state.led_level;
  assign result.data.evaluated   = evaluated;

endmodule

/* sv/dalt_eval.sv */
module dalt_eval (
  input  dalt_pkg::sample_word_t word,
  input  dalt_pkg::cfg_t         cfg,
  input  dalt_pkg::track_state_t state,
  output dalt_pkg::track_state_t state_next,
  output logic                   evaluated
);
  import dalt_pkg::*;

  // 0 when within the dead band
  function automatic logic [DriveW-1:0] choose(
    input logic [LightW:0]   a,
    input logic [LightW:0]   b,
    input logic [BiasW-1:0]  band,
    input logic [DriveW-1:0] when_a,
    input logic [DriveW-1:0] when_b
  );
    logic [LightW+1:0] a_ext;
    logic [LightW+1:0] b_ext;
    logic [LightW+1:0] band_ext;
    logic [DriveW-1:0] pick;
    a_ext    = {1'b0, a};
    b_ext    = {1'b0, b};
    band_ext = {2'b00, band};
    if (a_ext > b_ext + band_ext) begin
      pick = when_a;
    end else if (b_ext > a_ext + band_ext) begin
      pick = when_b;
    end else begin
      pick = '0;
    end
    return pick;
  endfunction

  logic [LightW:0]   sum_right, sum_left, sum_top, sum_bottom;
  logic [LightW:0]   avg_right, avg_left, avg_top, avg_bottom;
  logic [TickW-1:0]  tick_inc;
  logic              stop_hit;

  always_comb begin
    sum_right  = {1'b0, word.top_right_light} + {1'b0, word.bottom_right_light};
    sum_left   = {1'b0, word.bottom_left_light} + {1'b0, word.top_left_light};
    sum_top    = {1'b0, word.top_left_light} + {1'b0, word.top_right_light};
    sum_bottom = {1'b0, word.bottom_left_light} + {1'b0, word.bottom_right_light};

    avg_right  = {1'b0, sum_right[LightW:1]};
    avg_left   = {1'b0, sum_left[LightW:1]} + {1'b0, cfg.left_bias};
    avg_top    = {1'b0, sum_top[LightW:1]} + {1'b0, cfg.top_bias};
    avg_bottom = {1'b0, sum_bottom[LightW:1]};

    tick_inc  = state.tick_count + 4'd1;
    stop_hit  = (tick_inc == cfg.stop_tick);
    evaluated = (tick_inc >= cfg.sample_tick);

    state_next = state;
    state_next.tick_count = tick_inc;
    if (stop_hit) begin
      state_next.tilt_level = '0;
      state_next.pan_level  = '0;
    end
    // evaluation overrides a stop on the same tick
    if (evaluated) begin
      state_next.tick_count = '0;
      state_next.led_level  = avg_bottom[LedW-1:0];
      state_next.pan_level  = choose(avg_right, avg_left, cfg.dead_band,
                                     cfg.pan_ccw_drive, cfg.clockwise_drive);
      state_next.tilt_level = choose(avg_top, avg_bottom, cfg.dead_band,
                                     cfg.clockwise_drive, cfg.tilt_ccw_drive);
    end
  end

endmodule

/* sv/dalt_checker.sv */
module dalt_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  dalt_pkg::result_word_t out_data
);
  import dalt_pkg::*;

  logic              seen;
  logic [DriveW-1:0] last_tilt;
  logic [DriveW-1:0] last_pan;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen <= 1'b1;
    end
    if (out_valid && out_ready) begin
      last_tilt <= out_data.tilt_drive;
      last_pan  <= out_data.pan_drive;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // an idle pipe passes a word through the input and result registers
  a_word_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without a sample word");

  // a tick without evaluation either holds a level or stops it
  a_drive_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen && !out_data.evaluated |->
      (out_data.tilt_drive == last_tilt || out_data.tilt_drive == '0) &&
      (out_data.pan_drive == last_pan || out_data.pan_drive == '0))
    else $error("drive changed on a tick without evaluation");

endmodule

bind dual_axis_light_tracker dalt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

/* sim/testbench.sv */
module testbench;
  import dalt_pkg::*;

  // Mirror of the tracker: register copy, tick/level state and the queue of
  // result words still to come back.
  class tracker_scoreboard;
    cfg_t           regs;
    track_state_t   st;
    result_word_t   pending_q[$];
    int unsigned    mismatches;
    int unsigned    words_seen;

    function new();
      regs.clockwise_drive = CwDriveReset;
      regs.pan_ccw_drive   = PanCcwReset;
      regs.tilt_ccw_drive  = TiltCcwReset;
      regs.left_bias       = LeftBiasReset;
      regs.top_bias        = TopBiasReset;
      regs.dead_band       = DeadBandReset;
      regs.stop_tick       = StopTickReset;
      regs.sample_tick     = SampleTickReset;
      st = '0;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_CW_DRIVE:    regs.clockwise_drive = val;
        REG_PAN_CCW:     regs.pan_ccw_drive   = val;
        REG_TILT_CCW:    regs.tilt_ccw_drive  = val;
        REG_LEFT_BIAS:   regs.left_bias       = val[BiasW-1:0];
        REG_TOP_BIAS:    regs.top_bias        = val[BiasW-1:0];
        REG_DEAD_BAND:   regs.dead_band       = val[BiasW-1:0];
        REG_STOP_TICK:   regs.stop_tick       = val[TickW-1:0];
        REG_SAMPLE_TICK: regs.sample_tick     = val[TickW-1:0];
        default: ;
      endcase
    endfunction

    // dead-band decision: a must clear b by more than the band, and vice versa
    function logic [DriveW-1:0] steer(int unsigned a, int unsigned b,
                                      logic [DriveW-1:0] when_a,
                                      logic [DriveW-1:0] when_b);
      int unsigned band;
      band = regs.dead_band;
      if (a > b + band)
        return when_a;
      if (b > a + band)
        return when_b;
      return '0;
    endfunction

    function void note_sample(sample_word_t s);
      int unsigned  right_avg, left_avg, top_avg, bottom_avg;
      int unsigned  tl, tr, bl, br;
      result_word_t r;
      tl = s.top_left_light;
      tr = s.top_right_light;
      bl = s.bottom_left_light;
      br = s.bottom_right_light;
      r.evaluated = 1'b0;
      st.tick_count = st.tick_count + 1'b1;
      if (st.tick_count == regs.stop_tick) begin
        st.tilt_level = '0;
        st.pan_level  = '0;
      end
      if (st.tick_count >= regs.sample_tick) begin
        right_avg  = (tr + br) >> 1;
        left_avg   = ((bl + tl) >> 1) + regs.left_bias;
        top_avg    = ((tl + tr) >> 1) + regs.top_bias;
        bottom_avg = (bl + br) >> 1;
        st.tick_count = '0;
        st.led_level  = bottom_avg[LedW-1:0];
        st.pan_level  = steer(right_avg, left_avg, regs.pan_ccw_drive,
                              regs.clockwise_drive);
        st.tilt_level = steer(top_avg, bottom_avg, regs.clockwise_drive,
                              regs.tilt_ccw_drive);
        r.evaluated = 1'b1;
      end
      r.tilt_drive  = st.tilt_level;
      r.pan_drive   = st.pan_level;
      r.led_pattern = st.led_level;
      pending_q.push_back(r);
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      words_seen++;
      if (pending_q.size() == 0) begin
        report($sformatf("word %0d: unexpected result %h", words_seen, got));
        return;
      end
      want = pending_q.pop_front();
      if (got.tilt_drive !== want.tilt_drive)
        report($sformatf("word %0d: tilt_drive %0d, want %0d",
                         words_seen, got.tilt_drive, want.tilt_drive));
      if (got.pan_drive !== want.pan_drive)
        report($sformatf("word %0d: pan_drive %0d, want %0d",
                         words_seen, got.pan_drive, want.pan_drive));
      if (got.led_pattern !== want.led_pattern)
        report($sformatf("word %0d: led_pattern %h, want %h",
                         words_seen, got.led_pattern, want.led_pattern));
      if (got.evaluated !== want.evaluated)
        report($sformatf("word %0d: evaluated %b, want %b",
                         words_seen, got.evaluated, want.evaluated));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dalt_sample_if samples_ch ();
  dalt_result_if result_ch ();

  dual_axis_light_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tracker_scoreboard sb = new();

  int unsigned burst_left;
  bit          calm;
  logic [15:0] stall_pattern = '1;
  int unsigned rx_cycle = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: check on each accepted word, stall on a rotating pattern
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.data);
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 48 == 0) begin
      case ($urandom_range(3))
        0: stall_pattern <= '1;
        1: stall_pattern <= ($urandom() & $urandom()) | 16'h1;
        default: stall_pattern <= $urandom() | 16'h1;
      endcase
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
    result_ch.ready <= stall_pattern[0];
  end

  function automatic logic [LightW-1:0] clip_light(int v);
    if (v < 0)
      return '0;
    if (v > 1023)
      return '1;
    return v[LightW-1:0];
  endfunction

  function automatic sample_word_t lights(int tl, int tr, int bl, int br);
    sample_word_t s;
    s.top_left_light     = clip_light(tl);
    s.top_right_light    = clip_light(tr);
    s.bottom_left_light  = clip_light(bl);
    s.bottom_right_light = clip_light(br);
    return s;
  endfunction

  // Mostly readings placed so that both pair differences land near the
  // dead band edges, the rest uniform.
  function automatic sample_word_t random_lights();
    int tl, lb, tb, db, j, k;
    if ($urandom_range(9) < 4)
      return lights($urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023), $urandom_range(1023));
    lb = sb.regs.left_bias;
    tb = sb.regs.top_bias;
    db = sb.regs.dead_band;
    tl = $urandom_range(1023);
    j  = int'($urandom_range(2 * db + 6)) - (db + 3);
    k  = int'($urandom_range(2 * db + 6)) - (db + 3);
    return lights(tl, tl + lb + j, tl + tb + k, tl + tb + k + lb + j);
  endfunction

  function automatic cfg_t make_setup(int cw, int pan, int tilt, int lb,
                                      int tb, int db, int stop, int samp);
    cfg_t c;
    c.clockwise_drive = cw;
    c.pan_ccw_drive   = pan;
    c.tilt_ccw_drive  = tilt;
    c.left_bias       = lb;
    c.top_bias        = tb;
    c.dead_band       = db;
    c.stop_tick       = stop;
    c.sample_tick     = samp;
    return c;
  endfunction

  function automatic cfg_t random_setup();
    int lb, tb, db;
    lb = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(200);
    tb = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(200);
    db = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(60);
    return make_setup($urandom_range(49999), $urandom_range(49999),
                      $urandom_range(49999), lb, tb, db,
                      $urandom_range(15), $urandom_range(15));
  endfunction

  task automatic send_sample(input sample_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = calm ? 100000 : $urandom_range(1, 16);
      gap = calm ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        samples_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    samples_ch.valid <= 1'b1;
    samples_ch.data  <= w;
    @(posedge clk);
    while (!samples_ch.ready)
      @(posedge clk);
    sb.note_sample(w);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0)
      @(posedge clk);
  endtask

  // all eight registers, written back to back once the pipe is empty
  task automatic program_regs(input cfg_t c);
    cfg_index_t          idx;
    logic [CfgDataW-1:0] v;
    drain();
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        REG_CW_DRIVE:    v = c.clockwise_drive;
        REG_PAN_CCW:     v = c.pan_ccw_drive;
        REG_TILT_CCW:    v = c.tilt_ccw_drive;
        REG_LEFT_BIAS:   v = c.left_bias;
        REG_TOP_BIAS:    v = c.top_bias;
        REG_DEAD_BAND:   v = c.dead_band;
        REG_STOP_TICK:   v = c.stop_tick;
        default:         v = c.sample_tick;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= v;
      @(posedge clk);
      sb.write_reg(idx, v);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    calm = ($urandom_range(3) == 0);
    burst_left = 0;
    repeat (count)
      send_sample(random_lights());
    samples_ch.valid <= 1'b0;
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_CW_DRIVE;
    cfg_data         <= '0;
    samples_ch.valid <= 1'b0;
    samples_ch.data  <= '0;
    burst_left = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: evaluation on the fifth tick, stop on the third
    send_sample(lights(0, 0, 0, 0));
    send_sample(lights(1023, 1023, 1023, 1023));
    send_sample(lights(1023, 0, 1023, 0));
    send_sample(lights(0, 1023, 0, 1023));
    send_sample(lights(300, 450, 500, 700));
    samples_ch.valid <= 1'b0;

    // evaluate every tick, stop on the same tick; dead band edges per word
    program_regs(make_setup(3500, 3890, 4000, 100, 160, 20, 1, 1));
    send_sample(lights(0, 0, 0, 0));
    send_sample(lights(1023, 1023, 1023, 1023));
    send_sample(lights(1023, 0, 0, 0));
    send_sample(lights(0, 1023, 0, 0));
    send_sample(lights(0, 0, 1023, 0));
    send_sample(lights(0, 0, 0, 1023));
    send_sample(lights(0, 120, 0, 120));   // pan exactly on the band: stop
    send_sample(lights(0, 121, 0, 121));   // just over: counterclockwise
    send_sample(lights(0, 80, 0, 80));
    send_sample(lights(0, 79, 0, 79));     // left wins: clockwise
    send_sample(lights(0, 0, 180, 180));   // tilt exactly on the band
    send_sample(lights(0, 0, 181, 181));   // bottom wins: tilt ccw
    send_sample(lights(1023, 1022, 1021, 1020));
    send_sample(lights(0, 0, 511, 511));
    send_sample(lights(1, 0, 1023, 1022));
    samples_ch.valid <= 1'b0;

    program_regs(make_setup(3500, 3890, 4000, 100, 160, 20, 3, 5));
    run_phase(60);
    // widest sums, drives past the period, slowest evaluation
    program_regs(make_setup(65535, 50000, 49999, 1023, 1023, 1023, 15, 15));
    run_phase(60);
    // sample tick now 2; the last phase ends on an evaluation, so the count starts at zero
    program_regs(make_setup(12000, 0, 65535, 5, 5, 0, 1, 2));
    run_phase(50);
    // everything at zero: every tick evaluates
    program_regs(make_setup(0, 0, 0, 0, 0, 0, 0, 0));
    run_phase(50);
    program_regs(make_setup(4000, 3000, 2000, 40, 70, 10, 4, 4));
    run_phase(60);
    repeat (6) begin
      program_regs(random_setup());
      run_phase(50);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending_q.size()));
    if (sb.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
sv/dalt_pkg.sv
sv/dalt_sample_if.sv
sv/dalt_result_if.sv
sv/dalt_eval.sv
sv/dual_axis_light_tracker.sv
sv/dalt_checker.sv
sim/testbench.sv
